FILE: src/rpkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read pair k-mer dedup package
// Shared sizes, verdict codes, register indexes and key helper functions.
// ----------------------------------------------------------------------------
package rpkd_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int HALF_BASES    = 19;
    localparam int MAX_PROBES    = 16;

    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int HALF_W   = 2 * HALF_BASES;
    localparam int KEY_W    = 2 * HALF_W;
    localparam int WORD_W   = KEY_W + 1;
    localparam int FILL_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int PROBE_W  = $clog2(MAX_PROBES + 1);
    localparam int LEN_W    = 16;
    localparam int MAPQ_W   = 8;
    localparam int VERD_W   = 3;
    localparam int RIDX_W   = 8;
    localparam int RDATA_W  = 8;

    localparam logic [VERD_W-1:0] VERDICT_NEW     = 3'd0;
    localparam logic [VERD_W-1:0] VERDICT_DUP     = 3'd1;
    localparam logic [VERD_W-1:0] VERDICT_LOWMAPQ = 3'd2;
    localparam logic [VERD_W-1:0] VERDICT_SKIP    = 3'd3;
    localparam logic [VERD_W-1:0] VERDICT_FULL    = 3'd4;

    localparam logic [RIDX_W-1:0] REG_DEDUP_EN    = 8'd0;
    localparam logic [RIDX_W-1:0] REG_MIN_MAPQ    = 8'd1;
    localparam logic [RIDX_W-1:0] REG_ZERO_EXEMPT = 8'd2;

    // reverse the base order of one half
    function automatic logic [HALF_W-1:0] rev_bases(input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] r;
        r = '0;
        for (int i = 0; i < HALF_BASES; i++) begin
            r[2*i +: 2] = v[2*(HALF_BASES-1-i) +: 2];
        end
        return r;
    endfunction

    // xor-fold hash to a home slot
    function automatic logic [IDX_W-1:0] home_slot(input logic [HALF_W-1:0] lo,
                                                    input logic [HALF_W-1:0] hi);
        logic [HALF_W-1:0] x0;
        logic [HALF_W-1:0] x1;
        logic [HALF_W-1:0] x2;
        x0 = lo ^ hi;
        x1 = x0 ^ (x0 >> 32);
        x2 = x1 ^ (x1 >> 16);
        return x2[IDX_W-1:0];
    endfunction

endpackage

FILE: src/rpkd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read pair k-mer dedup channels
// Pair input, verdict output and register write channels.
// ----------------------------------------------------------------------------
interface rpkd_pair_if;
    logic                               valid;
    logic                               ready;
    logic [rpkd_pkg::HALF_W-1:0]        first_read_bases;
    logic [rpkd_pkg::HALF_W-1:0]        second_read_bases;
    logic [rpkd_pkg::LEN_W-1:0]         first_read_length;
    logic [rpkd_pkg::LEN_W-1:0]         second_read_length;
    logic [rpkd_pkg::MAPQ_W-1:0]        first_read_mapq;
    logic [rpkd_pkg::MAPQ_W-1:0]        second_read_mapq;

    modport source (output valid, first_read_bases, second_read_bases,
                    first_read_length, second_read_length,
                    first_read_mapq, second_read_mapq, input ready);
    modport sink   (input valid, first_read_bases, second_read_bases,
                    first_read_length, second_read_length,
                    first_read_mapq, second_read_mapq, output ready);
endinterface

interface rpkd_result_if;
    logic                               valid;
    logic                               ready;
    logic [rpkd_pkg::VERD_W-1:0]        verdict;
    logic [rpkd_pkg::FILL_W-1:0]        entries_used;

    modport source (output valid, verdict, entries_used, input ready);
    modport sink   (input valid, verdict, entries_used, output ready);
endinterface

interface rpkd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rpkd_pkg::RIDX_W-1:0]        index;
    logic [rpkd_pkg::RDATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/read_pair_kmer_dedup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read pair k-mer dedup
// Filters read pairs on mapping quality and length, then marks duplicates
// by a canonical 38-base paired key held in an open-addressed hash table.
//
// Channels: i_pair takes one read pair per beat, o_result gives one verdict
// and the table fill per pair, i_cfg writes the three control registers
// (always ready; write only while the block is idle).
// Steps: a pair removed or skipped by the filters goes from acceptance
// straight to DONE; a pair that reaches the table passes KEY, HASH and one
// PROBE step per slot probed, P of them (1 to 16), then DONE. The next pair
// is taken once DONE has passed the result on and returned to IDLE; the
// table is one memory with a registered read, read once per probe.
// Reset: the table memory is cleared one slot per cycle, all 4096 slots,
// while no pair is accepted; registers return to dedup on, filter off.
// Stall: the result register holds while o_result.ready is low; one more
// pair may be accepted and processed, and waits for the register to free.
// ----------------------------------------------------------------------------
module read_pair_kmer_dedup (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    rpkd_pair_if.sink              i_pair,
    rpkd_result_if.source          o_result,
    rpkd_cfg_if.sink               i_cfg
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_KEY   = 3'd2;
    localparam logic [2:0] S_HASH  = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                         r_state, n_state;
    logic [rpkd_pkg::IDX_W-1:0]         r_clr_addr, n_clr_addr;
    logic [rpkd_pkg::IDX_W-1:0]         r_slot, n_slot;
    logic [rpkd_pkg::PROBE_W-1:0]       r_probe, n_probe;
    logic [rpkd_pkg::FILL_W-1:0]        r_fill, n_fill;
    logic [rpkd_pkg::VERD_W-1:0]        r_verdict, n_verdict;
    logic [rpkd_pkg::HALF_W-1:0]        r_b1, r_b2;
    logic [rpkd_pkg::KEY_W-1:0]         r_key;
    logic                               r_out_valid, n_out_valid;
    logic [rpkd_pkg::VERD_W-1:0]        r_out_verdict;
    logic [rpkd_pkg::FILL_W-1:0]        r_out_used;

    logic                               r_dedup_en;
    logic [rpkd_pkg::MAPQ_W-1:0]        r_min_mapq;
    logic                               r_zero_exempt;

    logic [rpkd_pkg::WORD_W-1:0]        r_mem [rpkd_pkg::TABLE_ENTRIES];
    logic [rpkd_pkg::WORD_W-1:0]        r_rd_word;

    logic                               w_in_beat;
    logic                               w_out_free;
    logic                               w_low1, w_low2, w_removed, w_short;
    logic [rpkd_pkg::HALF_W-1:0]        w_lo, w_hi, w_rlo, w_rhi;
    logic                               w_take_rc;
    logic [rpkd_pkg::KEY_W-1:0]         w_canon;
    logic                               w_empty, w_match, w_last;
    logic                               w_rd_en, w_wr_en;
    logic [rpkd_pkg::IDX_W-1:0]         w_rd_addr, w_wr_addr;
    logic [rpkd_pkg::WORD_W-1:0]        w_wr_data;

    assign i_pair.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_in_beat    = i_pair.valid && i_pair.ready;
    assign w_out_free   = !r_out_valid || o_result.ready;

    assign o_result.valid        = r_out_valid;
    assign o_result.verdict      = r_out_verdict;
    assign o_result.entries_used = r_out_used;

    // filters on the incoming beat
    assign w_low1 = (i_pair.first_read_mapq < r_min_mapq) &&
                    ((i_pair.first_read_mapq != '0) || !r_zero_exempt);
    assign w_low2 = (i_pair.second_read_mapq < r_min_mapq) &&
                    ((i_pair.second_read_mapq != '0) || !r_zero_exempt);
    assign w_removed = (r_min_mapq != '0) && (w_low1 || w_low2);
    assign w_short   = !r_dedup_en ||
        (i_pair.first_read_length  < rpkd_pkg::LEN_W'(rpkd_pkg::KEY_W / 2)) ||
        (i_pair.second_read_length < rpkd_pkg::LEN_W'(rpkd_pkg::KEY_W / 2));

    // canonical key: base 0 compared first, so compare base-reversed words
    assign w_lo  = r_b1;
    assign w_hi  = rpkd_pkg::rev_bases(r_b2);
    assign w_rlo = ~r_b2;
    assign w_rhi = ~rpkd_pkg::rev_bases(r_b1);
    assign w_take_rc = {rpkd_pkg::rev_bases(w_rlo), r_b1 ^ {rpkd_pkg::HALF_W{1'b1}}} <
                       {rpkd_pkg::rev_bases(w_lo), r_b2};
    assign w_canon = w_take_rc ? {w_rhi, w_rlo} : {w_hi, w_lo};

    assign w_empty = !r_rd_word[rpkd_pkg::KEY_W];
    assign w_match = (r_rd_word[rpkd_pkg::KEY_W-1:0] == r_key);
    assign w_last  = (r_probe == rpkd_pkg::PROBE_W'(rpkd_pkg::MAX_PROBES - 1));

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_slot + 1'b1;
        w_wr_en   = 1'b0;
        w_wr_addr = r_slot;
        w_wr_data = {1'b1, r_key};
        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_addr;
                w_wr_data = '0;
            end
            S_HASH: begin
                w_rd_en   = 1'b1;
                w_rd_addr = rpkd_pkg::home_slot(r_key[rpkd_pkg::HALF_W-1:0],
                                                r_key[rpkd_pkg::KEY_W-1:rpkd_pkg::HALF_W]);
            end
            S_PROBE: begin
                if (w_empty) begin
                    w_wr_en = 1'b1;
                end else if (!w_match && !w_last) begin
                    w_rd_en = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_slot      = r_slot;
        n_probe     = r_probe;
        n_fill      = r_fill;
        n_verdict   = r_verdict;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == {rpkd_pkg::IDX_W{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_beat) begin
                    if (w_removed) begin
                        n_verdict = rpkd_pkg::VERDICT_LOWMAPQ;
                        n_state   = S_DONE;
                    end else if (w_short) begin
                        n_verdict = rpkd_pkg::VERDICT_SKIP;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_KEY;
                    end
                end
            end
            S_KEY: begin
                n_state = S_HASH;
            end
            S_HASH: begin
                n_slot  = w_rd_addr;
                n_probe = '0;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (w_empty) begin
                    n_fill    = r_fill + 1'b1;
                    n_verdict = rpkd_pkg::VERDICT_NEW;
                    n_state   = S_DONE;
                end else if (w_match) begin
                    n_verdict = rpkd_pkg::VERDICT_DUP;
                    n_state   = S_DONE;
                end else if (w_last) begin
                    n_verdict = rpkd_pkg::VERDICT_FULL;
                    n_state   = S_DONE;
                end else begin
                    n_slot  = w_rd_addr;
                    n_probe = r_probe + 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_fill        <= '0;
            r_out_valid   <= 1'b0;
            r_dedup_en    <= 1'b1;
            r_min_mapq    <= '0;
            r_zero_exempt <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    rpkd_pkg::REG_DEDUP_EN:    r_dedup_en    <= i_cfg.data[0];
                    rpkd_pkg::REG_MIN_MAPQ:    r_min_mapq    <= i_cfg.data[rpkd_pkg::MAPQ_W-1:0];
                    rpkd_pkg::REG_ZERO_EXEMPT: r_zero_exempt <= i_cfg.data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_slot    <= n_slot;
        r_probe   <= n_probe;
        r_verdict <= n_verdict;
        if (w_in_beat) begin
            r_b1 <= i_pair.first_read_bases;
            r_b2 <= i_pair.second_read_bases;
        end
        if (r_state == S_KEY) begin
            r_key <= w_canon;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_verdict <= r_verdict;
            r_out_used    <= r_fill;
        end
    end

    // slot table: valid bit over key
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_word <= r_mem[w_rd_addr];
        end
    end

endmodule

FILE: src/rpkd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read pair k-mer dedup checker
// Port-level properties of the dedup block, attached by bind.
// ----------------------------------------------------------------------------
module rpkd_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pair_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [rpkd_pkg::VERD_W-1:0]   i_verdict,
    input  logic [rpkd_pkg::FILL_W-1:0]   i_entries_used
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_verdict) && $stable(i_entries_used))
        else $error("result beat changed while stalled");

    // table is being cleared right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pair_ready)
        else $error("pair accepted during table clear");

    // a stored or found key means the table is not empty
    a_hit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_verdict == rpkd_pkg::VERDICT_NEW ||
                        i_verdict == rpkd_pkg::VERDICT_DUP) |-> i_entries_used != '0)
        else $error("new or duplicate verdict with empty table");

    // fill never exceeds the table
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            i_entries_used <= rpkd_pkg::FILL_W'(rpkd_pkg::TABLE_ENTRIES))
        else $error("entries_used beyond table size");

endmodule

bind read_pair_kmer_dedup rpkd_checker u_rpkd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_pair_ready   (i_pair.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_verdict      (o_result.verdict),
    .i_entries_used (o_result.entries_used)
);
